FILE: src/adl_pkg.sv
// Package for the Adler-32 checksum block.
// Holds the modulus, the fold constant and the per-item control struct.
// No dependencies.
`default_nettype none
package adl_pkg;

  localparam int unsigned CNT_W    = 4;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned WEIGHT_W = 12;
  localparam int unsigned SUM16_W  = 16;
  localparam int unsigned BSUM_W   = 20;

  localparam logic [16:0] ADLER_MOD = 17'd65521;
  localparam logic [16:0] FOLD_K    = 17'd15;   // 2^16 mod 65521
  localparam logic [31:0] SEED_RST  = 32'd1;
  localparam logic [15:0] LOW_RST   = 16'd1;
  localparam logic [15:0] HIGH_RST  = 16'd0;

  typedef struct packed {
    logic             first;
    logic             last;
    logic [CNT_W-1:0] cnt;
  } adl_ctl_t;

endpackage
`default_nettype wire

FILE: src/adl_lane.sv
// One byte lane: masks its byte and forms its weight for the high sum.
// Depends on adl_pkg.
`default_nettype none
module adl_lane
  import adl_pkg::*;
#(
  parameter int LANE = 0
) (
  input  wire logic [BYTE_W-1:0]   byte_in,
  input  wire logic [CNT_W-1:0]    cnt,
  output logic      [BYTE_W-1:0]   byte_out,
  output logic      [WEIGHT_W-1:0] weight
);

  localparam logic [CNT_W-1:0] LANE_IDX = CNT_W'(LANE);

  logic             active;
  logic [CNT_W-1:0] mult;

  always_comb begin
    active = (LANE_IDX < cnt);
    mult   = cnt - LANE_IDX;
    if (active) begin
      byte_out = byte_in;
      weight   = WEIGHT_W'(mult) * WEIGHT_W'(byte_in);
    end else begin
      byte_out = '0;
      weight   = '0;
    end
  end

endmodule
`default_nettype wire

FILE: src/adl_merge.sv
// Merge stage: adds the lane bytes and weights and registers them with control.
// Depends on adl_pkg.
`default_nettype none
module adl_merge
  import adl_pkg::*;
#(
  parameter int N      = 8,
  parameter int SUM_W  = 11,
  parameter int WSUM_W = 14
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  load,
  input  wire logic                  drain,
  input  wire logic [N*BYTE_W-1:0]   lane_bytes,
  input  wire logic [N*WEIGHT_W-1:0] lane_weights,
  input  wire adl_ctl_t              ctl_in,
  output logic                       valid,
  output adl_ctl_t                   ctl_out,
  output logic      [SUM_W-1:0]      byte_sum,
  output logic      [WSUM_W-1:0]     weight_sum
);

  logic              valid_r;
  adl_ctl_t          ctl_r;
  logic [SUM_W-1:0]  bsum_r, bsum_nxt;
  logic [WSUM_W-1:0] wsum_r, wsum_nxt;

  always_comb begin
    bsum_nxt = '0;
    wsum_nxt = '0;
    for (int i = 0; i < N; i++) begin
      bsum_nxt = bsum_nxt + SUM_W'(lane_bytes[i*BYTE_W +: BYTE_W]);
      wsum_nxt = wsum_nxt + WSUM_W'(lane_weights[i*WEIGHT_W +: WEIGHT_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (drain) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ctl_r  <= ctl_in;
      bsum_r <= bsum_nxt;
      wsum_r <= wsum_nxt;
    end
  end

  assign valid      = valid_r;
  assign ctl_out    = ctl_r;
  assign byte_sum   = bsum_r;
  assign weight_sum = wsum_r;

endmodule
`default_nettype wire

FILE: src/adl_acc.sv
// Running sums: applies one merged item and reduces both sums mod 65521.
// Depends on adl_pkg.
`default_nettype none
module adl_acc
  import adl_pkg::*;
#(
  parameter int SUM_W  = 11,
  parameter int WSUM_W = 14
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic [31:0]       seed,
  input  wire adl_ctl_t          ctl,
  input  wire logic [SUM_W-1:0]  byte_sum,
  input  wire logic [WSUM_W-1:0] weight_sum,
  output logic      [31:0]       sum_nxt,
  output logic      [31:0]       sum_cur
);

  logic [SUM16_W-1:0] low_r, low_nxt;
  logic [SUM16_W-1:0] high_r, high_nxt;
  logic [SUM16_W-1:0] a_base, b_base;
  logic [16:0]        a_sum, a_red;
  logic [BSUM_W-1:0]  b_sum;
  logic [16:0]        b_fold, b_red;

  always_comb begin
    a_base = ctl.first ? seed[15:0]  : low_r;
    b_base = ctl.first ? seed[31:16] : high_r;
    a_sum  = 17'(a_base) + 17'(byte_sum);
    b_sum  = BSUM_W'(b_base) + BSUM_W'(ctl.cnt) * BSUM_W'(a_base) + BSUM_W'(weight_sum);
    b_fold = 17'(b_sum[15:0]) + 17'(b_sum[BSUM_W-1:16]) * FOLD_K;
    a_red  = (a_sum  >= ADLER_MOD) ? a_sum  - ADLER_MOD : a_sum;
    b_red  = (b_fold >= ADLER_MOD) ? b_fold - ADLER_MOD : b_fold;
    if (ctl.cnt != '0) begin
      low_nxt  = a_red[15:0];
      high_nxt = b_red[15:0];
    end else begin
      low_nxt  = a_base;
      high_nxt = b_base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= LOW_RST;
      high_r <= HIGH_RST;
    end else if (step) begin
      low_r  <= low_nxt;
      high_r <= high_nxt;
    end
  end

  assign sum_nxt = {high_nxt, low_nxt};
  assign sum_cur = {high_r, low_r};

endmodule
`default_nettype wire

FILE: src/adler32_checksum.sv
// Top level of the streaming Adler-32 checksum block.
// Depends on adl_pkg, adl_lane, adl_merge and adl_acc.
//
//   channel | handshake             | payload
//   --------+-----------------------+------------------------------------------
//   in      | in_valid / in_ready   | in_data, in_byte_count, in_first, in_last
//   out     | out_valid / out_ready | out_checksum
//   cfg     | cfg_wr_en             | cfg_wr_data (seed)
//
// One transaction per cycle sustained unless a last item is held in stage one.
// The lanes and the adder tree form stage one, the running-sum update with the
// mod 65521 fold forms stage two; the update loop closes through low_r and high_r.
// Items without last leave stage one at once; a last item waits in stage one while
// the output register is full and not taken, and the input stalls behind it.
// Reset is synchronous and needs no clearing pass.
`default_nettype none
module adler32_checksum
  import adl_pkg::*;
#(
  parameter int BYTES_PER_ITEM = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_wr_en,
  input  wire logic [31:0]                  cfg_wr_data,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [BYTES_PER_ITEM*8-1:0]  in_data,
  input  wire logic [CNT_W-1:0]             in_byte_count,
  input  wire logic                         in_first,
  input  wire logic                         in_last,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [31:0]                  out_checksum
);

  localparam int N      = BYTES_PER_ITEM;
  localparam int SUM_W  = $clog2(N * 255 + 1);
  localparam int WSUM_W = $clog2((N * (N + 1) / 2) * 255 + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(N);

  logic [31:0]           seed_r;
  logic [CNT_W-1:0]      cnt_sat;
  adl_ctl_t              in_ctl, s1_ctl;
  logic [N*BYTE_W-1:0]   lane_bytes;
  logic [N*WEIGHT_W-1:0] lane_weights;
  logic                  s1_valid, load, drain;
  logic [SUM_W-1:0]      s1_bsum;
  logic [WSUM_W-1:0]     s1_wsum;
  logic [31:0]           acc_nxt, acc_cur;
  logic                  out_valid_r;
  logic [31:0]           out_checksum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_RST;
    end else if (cfg_wr_en) begin
      seed_r <= cfg_wr_data;
    end
  end

  assign cnt_sat = (in_byte_count > CNT_MAX) ? CNT_MAX : in_byte_count;
  assign in_ctl  = '{first: in_first, last: in_last, cnt: cnt_sat};

  for (genvar g = 0; g < N; g++) begin : g_lane
    adl_lane #(.LANE(g)) u_lane (
      .byte_in  (in_data[g*BYTE_W +: BYTE_W]),
      .cnt      (cnt_sat),
      .byte_out (lane_bytes[g*BYTE_W +: BYTE_W]),
      .weight   (lane_weights[g*WEIGHT_W +: WEIGHT_W])
    );
  end

  assign drain    = s1_valid && (!s1_ctl.last || !out_valid_r || out_ready);
  assign in_ready = !s1_valid || drain;
  assign load     = in_valid && in_ready;

  adl_merge #(.N(N), .SUM_W(SUM_W), .WSUM_W(WSUM_W)) u_merge (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (load),
    .drain        (drain),
    .lane_bytes   (lane_bytes),
    .lane_weights (lane_weights),
    .ctl_in       (in_ctl),
    .valid        (s1_valid),
    .ctl_out      (s1_ctl),
    .byte_sum     (s1_bsum),
    .weight_sum   (s1_wsum)
  );

  adl_acc #(.SUM_W(SUM_W), .WSUM_W(WSUM_W)) u_acc (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (drain),
    .seed       (seed_r),
    .ctl        (s1_ctl),
    .byte_sum   (s1_bsum),
    .weight_sum (s1_wsum),
    .sum_nxt    (acc_nxt),
    .sum_cur    (acc_cur)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (drain && s1_ctl.last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (drain && s1_ctl.last) begin
      out_checksum_r <= acc_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_checksum = out_checksum_r;

  a_sums_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (drain && s1_ctl.cnt != '0) |=>
      (17'(acc_cur[15:0]) < ADLER_MOD && 17'(acc_cur[31:16]) < ADLER_MOD))
    else $error("running sums not reduced");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (drain && s1_ctl.last) |=> (out_valid && out_checksum == $past(acc_nxt)))
    else $error("result not loaded into output register");

  a_last_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && s1_ctl.last && out_valid_r && !out_ready) |=> s1_valid)
    else $error("last transaction dropped while output stalled");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid |-> in_ready)
    else $error("empty stage refuses input");

endmodule
`default_nettype wire
